>>> sv/ptc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants for the first-order pressure and temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // Field widths
  localparam int unsigned CalW      = 16;
  localparam int unsigned RawW      = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned TempCW    = 19;
  localparam int unsigned TempMW    = 23;
  localparam int unsigned PresTW    = 26;
  localparam int unsigned PresPaW   = 30;

  // Internal widths
  localparam int unsigned DtW       = 25;  // D2 - C5 * 2^8
  localparam int unsigned CoefProdW = 42;  // dT * Cx
  localparam int unsigned OffW      = 36;
  localparam int unsigned SensW     = 34;
  localparam int unsigned SensLoW   = 17;
  localparam int unsigned PLoW      = 41;  // D1 * SENS low half
  localparam int unsigned PHiW      = 42;  // D1 * SENS high half
  localparam int unsigned PFullW    = 59;
  localparam int unsigned Q21W      = 38;
  localparam int unsigned PDiffW    = 39;

  localparam logic signed [TempCW-1:0] TempBase = 19'sd2000;

  // Pipeline stages, in order
  localparam int unsigned NumStages = 8;
  localparam int unsigned StgDt     = 0;
  localparam int unsigned StgCoef   = 1;
  localparam int unsigned StgComp   = 2;
  localparam int unsigned StgPMul   = 3;
  localparam int unsigned StgPSum   = 4;
  localparam int unsigned StgPDiv   = 5;
  localparam int unsigned StgPOff   = 6;
  localparam int unsigned StgOut    = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CfgC1 = 3'd0,
    CfgC2 = 3'd1,
    CfgC3 = 3'd2,
    CfgC4 = 3'd3,
    CfgC5 = 3'd4,
    CfgC6 = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
  } cal_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctrl_t;

endpackage
`default_nettype wire

>>> sv/pressure_temperature_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// First-order compensation of raw D1/D2 conversions into temperature and
// pressure using six calibration words.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_stall_o    raw_pressure_i, raw_temperature_i
//   out      out_valid_o / out_stall_i  temp_centi_c_o, temp_milli_c_o,
//                                       pressure_tenth_mbar_o, pressure_pa_o
//   cfg      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One beat per cycle unless in_stall_o holds the input; each beat passes through three
// front stages (dT, coefficient products, TEMP/OFF/SENS) and five pressure
// stages (D1 * SENS split in two 17-bit halves, recombine, scale, offset,
// output register).
// Reset clears all stage valid bits and the calibration words.
// A stall holds the output beat; empty stages behind it keep filling, so the
// input stalls only when every stage is occupied.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [ptc_pkg::RawW-1:0]           raw_pressure_i,
  input  wire logic [ptc_pkg::RawW-1:0]           raw_temperature_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [ptc_pkg::TempCW-1:0]       temp_centi_c_o,
  output logic signed [ptc_pkg::TempMW-1:0]       temp_milli_c_o,
  output logic signed [ptc_pkg::PresTW-1:0]       pressure_tenth_mbar_o,
  output logic signed [ptc_pkg::PresPaW-1:0]      pressure_pa_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [ptc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [ptc_pkg::CalW-1:0]           cfg_data_i
);
  import ptc_pkg::*;

  cal_t                      cal;
  pipe_ctrl_t                ctrl;
  logic [RawW-1:0]           d1;
  logic signed [TempCW-1:0]  temp;
  logic signed [OffW-1:0]    off;
  logic signed [SensW-1:0]   sens;

  assign cfg_ready_o = 1'b1;

  ptc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cal_o       (cal)
  );

  ptc_pipe_ctrl u_pipe_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  ptc_comp_front u_comp_front (
    .clk_i             (clk_i),
    .ctrl_i            (ctrl),
    .cal_i             (cal),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .d1_o              (d1),
    .temp_o            (temp),
    .off_o             (off),
    .sens_o            (sens)
  );

  ptc_press_back u_press_back (
    .clk_i                 (clk_i),
    .ctrl_i                (ctrl),
    .d1_i                  (d1),
    .temp_i                (temp),
    .off_i                 (off),
    .sens_i                (sens),
    .temp_centi_c_o        (temp_centi_c_o),
    .temp_milli_c_o        (temp_milli_c_o),
    .pressure_tenth_mbar_o (pressure_tenth_mbar_o),
    .pressure_pa_o         (pressure_pa_o)
  );

endmodule
`default_nettype wire

>>> sv/ptc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_cfg_regs
// Calibration word register file, written one word per beat.
// ----------------------------------------------------------------------------
module ptc_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [ptc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ptc_pkg::CalW-1:0]    cfg_data_i,
  output ptc_pkg::cal_t                    cal_o
);
  import ptc_pkg::*;

  cal_t cal_q;
  cal_t cal_d;

  always_comb begin
    cal_d = cal_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CfgC1:   cal_d.c1 = cfg_data_i;
        CfgC2:   cal_d.c2 = cfg_data_i;
        CfgC3:   cal_d.c3 = cfg_data_i;
        CfgC4:   cal_d.c4 = cfg_data_i;
        CfgC5:   cal_d.c5 = cfg_data_i;
        CfgC6:   cal_d.c6 = cfg_data_i;
        default: cal_d = cal_q;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

endmodule
`default_nettype wire

>>> sv/ptc_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_pipe_ctrl
// Stage valid bits and load enables; empty stages soak up a stall.
// ----------------------------------------------------------------------------
module ptc_pipe_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output ptc_pkg::pipe_ctrl_t ctrl_o
);
  import ptc_pkg::*;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] vld_d;
  logic [NumStages-1:0] load;

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    load[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (load[0]) begin
      vld_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (load[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !load[0];
  assign out_valid_o = vld_q[NumStages-1];
  assign ctrl_o.load = load;

  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output drains");

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted beat not held in first stage");

  a_one_beat_per_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(vld_q) <= $past($countones(vld_q)) + 1))
    else $error("occupancy grew by more than one beat");

endmodule
`default_nettype wire

>>> sv/ptc_comp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_comp_front
// First three stages: dT, the three coefficient products, then TEMP, OFF
// and SENS with truncation toward zero.
// ----------------------------------------------------------------------------
module ptc_comp_front (
  input  wire logic                          clk_i,
  input  wire ptc_pkg::pipe_ctrl_t           ctrl_i,
  input  wire ptc_pkg::cal_t                 cal_i,
  input  wire logic [ptc_pkg::RawW-1:0]      raw_pressure_i,
  input  wire logic [ptc_pkg::RawW-1:0]      raw_temperature_i,
  output logic [ptc_pkg::RawW-1:0]           d1_o,
  output logic signed [ptc_pkg::TempCW-1:0]  temp_o,
  output logic signed [ptc_pkg::OffW-1:0]    off_o,
  output logic signed [ptc_pkg::SensW-1:0]   sens_o
);
  import ptc_pkg::*;

  // Stage: dT
  logic [RawW-1:0]          d1_dt_q;
  logic signed [DtW-1:0]    dt_q;
  logic signed [DtW-1:0]    dt_d;

  // Stage: coefficient products
  logic [RawW-1:0]              d1_coef_q;
  logic signed [CoefProdW-1:0]  prod6_q, prod4_q, prod3_q;
  logic signed [CoefProdW-1:0]  prod6_d, prod4_d, prod3_d;

  // Stage: TEMP, OFF, SENS
  logic signed [CoefProdW-1:0]  sum6, sum4, sum3;
  logic signed [TempCW-1:0]     temp_d, temp_q;
  logic signed [OffW-1:0]       off_d, off_q;
  logic signed [SensW-1:0]      sens_d, sens_q;
  logic [RawW-1:0]              d1_comp_q;

  assign dt_d = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, cal_i.c5, 8'h00});

  assign prod6_d = dt_q * $signed({1'b0, cal_i.c6});
  assign prod4_d = dt_q * $signed({1'b0, cal_i.c4});
  assign prod3_d = dt_q * $signed({1'b0, cal_i.c3});

  // Bias negative values so the shift truncates toward zero.
  assign sum6 = prod6_q + (prod6_q[CoefProdW-1] ? 42'sd8388607 : 42'sd0);
  assign sum4 = prod4_q + (prod4_q[CoefProdW-1] ? 42'sd127 : 42'sd0);
  assign sum3 = prod3_q + (prod3_q[CoefProdW-1] ? 42'sd255 : 42'sd0);

  assign temp_d = $signed(sum6[CoefProdW-1:23]) + TempBase;
  assign off_d  = $signed({4'b0000, cal_i.c2, 16'h0000})
                + OffW'($signed(sum4[CoefProdW-1:7]));
  assign sens_d = $signed({3'b000, cal_i.c1, 15'h0000})
                + $signed(sum3[CoefProdW-1:8]);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[StgDt]) begin
      d1_dt_q <= raw_pressure_i;
      dt_q    <= dt_d;
    end
    if (ctrl_i.load[StgCoef]) begin
      d1_coef_q <= d1_dt_q;
      prod6_q   <= prod6_d;
      prod4_q   <= prod4_d;
      prod3_q   <= prod3_d;
    end
    if (ctrl_i.load[StgComp]) begin
      d1_comp_q <= d1_coef_q;
      temp_q    <= temp_d;
      off_q     <= off_d;
      sens_q    <= sens_d;
    end
  end

  assign d1_o   = d1_comp_q;
  assign temp_o = temp_q;
  assign off_o  = off_q;
  assign sens_o = sens_q;

endmodule
`default_nettype wire

>>> sv/ptc_press_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptc_press_back
// Last five stages: D1 * SENS in two halves, recombine, scale by 2^-21,
// remove OFF, scale by 2^-13, and form the output units.
// ----------------------------------------------------------------------------
module ptc_press_back (
  input  wire logic                           clk_i,
  input  wire ptc_pkg::pipe_ctrl_t            ctrl_i,
  input  wire logic [ptc_pkg::RawW-1:0]       d1_i,
  input  wire logic signed [ptc_pkg::TempCW-1:0] temp_i,
  input  wire logic signed [ptc_pkg::OffW-1:0]   off_i,
  input  wire logic signed [ptc_pkg::SensW-1:0]  sens_i,
  output logic signed [ptc_pkg::TempCW-1:0]   temp_centi_c_o,
  output logic signed [ptc_pkg::TempMW-1:0]   temp_milli_c_o,
  output logic signed [ptc_pkg::PresTW-1:0]   pressure_tenth_mbar_o,
  output logic signed [ptc_pkg::PresPaW-1:0]  pressure_pa_o
);
  import ptc_pkg::*;

  // Stage: split product
  logic [PLoW-1:0]          plo_d, plo_q;
  logic signed [PHiW-1:0]   phi_d, phi_q;
  logic signed [TempCW-1:0] temp_mul_q;
  logic signed [OffW-1:0]   off_mul_q;

  // Stage: full product
  logic signed [PFullW-1:0] x_d, x_q;
  logic signed [TempCW-1:0] temp_sum_q;
  logic signed [OffW-1:0]   off_sum_q;

  // Stage: divide by 2^21
  logic signed [PFullW-1:0] x_bias;
  logic signed [Q21W-1:0]   q21_d, q21_q;
  logic signed [TempCW-1:0] temp_div_q;
  logic signed [OffW-1:0]   off_div_q;

  // Stage: subtract OFF
  logic signed [PDiffW-1:0] y_d, y_q;
  logic signed [TempCW-1:0] temp_off_q;

  // Stage: output
  logic signed [PDiffW-1:0]  y_bias;
  logic signed [PresTW-1:0]  p_d, p_q;
  logic signed [PresPaW-1:0] pa_d, pa_q;
  logic signed [TempMW-1:0]  tm_d, tm_q;
  logic signed [TempCW-1:0]  tc_q;

  assign plo_d = d1_i * sens_i[SensLoW-1:0];
  assign phi_d = $signed({1'b0, d1_i}) * $signed(sens_i[SensW-1:SensLoW]);

  assign x_d = (PFullW'(phi_q) <<< SensLoW)
             + $signed({{(PFullW-PLoW){1'b0}}, plo_q});

  assign x_bias = x_q + (x_q[PFullW-1] ? 59'sd2097151 : 59'sd0);
  assign q21_d  = $signed(x_bias[PFullW-1:21]);

  assign y_d = PDiffW'(q21_q) - PDiffW'(off_div_q);

  assign y_bias = y_q + (y_q[PDiffW-1] ? 39'sd8191 : 39'sd0);
  assign p_d    = $signed(y_bias[PDiffW-1:13]);
  // times ten as 8x + 2x
  assign pa_d   = (PresPaW'(p_d) <<< 3) + (PresPaW'(p_d) <<< 1);
  assign tm_d   = (TempMW'(temp_off_q) <<< 3) + (TempMW'(temp_off_q) <<< 1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load[StgPMul]) begin
      plo_q      <= plo_d;
      phi_q      <= phi_d;
      temp_mul_q <= temp_i;
      off_mul_q  <= off_i;
    end
    if (ctrl_i.load[StgPSum]) begin
      x_q        <= x_d;
      temp_sum_q <= temp_mul_q;
      off_sum_q  <= off_mul_q;
    end
    if (ctrl_i.load[StgPDiv]) begin
      q21_q      <= q21_d;
      temp_div_q <= temp_sum_q;
      off_div_q  <= off_sum_q;
    end
    if (ctrl_i.load[StgPOff]) begin
      y_q        <= y_d;
      temp_off_q <= temp_div_q;
    end
    if (ctrl_i.load[StgOut]) begin
      p_q  <= p_d;
      pa_q <= pa_d;
      tc_q <= temp_off_q;
      tm_q <= tm_d;
    end
  end

  assign temp_centi_c_o        = tc_q;
  assign temp_milli_c_o        = tm_q;
  assign pressure_tenth_mbar_o = p_q;
  assign pressure_pa_o         = pa_q;

endmodule
`default_nettype wire
